// ===== sv/sifp_pkg.sv =====
// shared types, constants and draw tables for the synthetic imu flight profile
package sifp_pkg;

    localparam int IN_W    = 32;
    localparam int OUT_W   = 104;
    localparam int TIME_W  = 32;
    localparam int RAW_W   = 15;
    localparam int SPAN_W  = 10;
    localparam int RECIP_W = 21;
    localparam int RECIP_SH = 25;
    localparam int QUO_W   = 11;
    localparam int VAL_W   = 14;

    localparam logic [31:0] LCG_MUL    = 32'd1103515245;
    localparam logic [31:0] LCG_ADD    = 32'd12345;
    localparam logic [31:0] NOISE_SEED = 32'd42;

    localparam logic [31:0] PAD_END_RST     = 32'd5000;
    localparam logic [31:0] BOOST_END_RST   = 32'd15000;
    localparam logic [31:0] COAST_END_RST   = 32'd30000;
    localparam logic [31:0] DESCENT_END_RST = 32'd45000;

    // config register indexes
    localparam logic [1:0] REG_PAD_END     = 2'd0;
    localparam logic [1:0] REG_BOOST_END   = 2'd1;
    localparam logic [1:0] REG_COAST_END   = 2'd2;
    localparam logic [1:0] REG_DESCENT_END = 2'd3;

    // draw order
    localparam logic [2:0] DRW_AX = 3'd0;
    localparam logic [2:0] DRW_AY = 3'd1;
    localparam logic [2:0] DRW_AZ = 3'd2;
    localparam logic [2:0] DRW_GX = 3'd3;
    localparam logic [2:0] DRW_GY = 3'd4;
    localparam logic [2:0] DRW_GZ = 3'd5;

    // elapsed/5 by reciprocal, exact for elapsed below 2^14
    localparam logic [15:0] DIV5_RECIP = 16'd52429;
    localparam int          DIV5_SH    = 18;
    localparam logic [31:0] SAT_MS     = 32'd15000;

    localparam logic signed [VAL_W-1:0] THRUST_BASE = 14'sd3000;
    localparam logic signed [VAL_W-1:0] THRUST_MAX  = 14'sd6000;
    localparam logic signed [VAL_W-1:0] DRAG_BASE   = -14'sd500;
    localparam logic signed [VAL_W-1:0] DRAG_MIN    = -14'sd2000;

    // ceil(2^25 / span) for each noise span
    localparam logic [RECIP_W-1:0] RECIP_21  = 21'((2**RECIP_SH + 20) / 21);
    localparam logic [RECIP_W-1:0] RECIP_31  = 21'((2**RECIP_SH + 30) / 31);
    localparam logic [RECIP_W-1:0] RECIP_61  = 21'((2**RECIP_SH + 60) / 61);
    localparam logic [RECIP_W-1:0] RECIP_101 = 21'((2**RECIP_SH + 100) / 101);
    localparam logic [RECIP_W-1:0] RECIP_161 = 21'((2**RECIP_SH + 160) / 161);
    localparam logic [RECIP_W-1:0] RECIP_201 = 21'((2**RECIP_SH + 200) / 201);
    localparam logic [RECIP_W-1:0] RECIP_301 = 21'((2**RECIP_SH + 300) / 301);
    localparam logic [RECIP_W-1:0] RECIP_401 = 21'((2**RECIP_SH + 400) / 401);
    localparam logic [RECIP_W-1:0] RECIP_601 = 21'((2**RECIP_SH + 600) / 601);

    typedef enum logic [2:0] {
        PH_PAD,
        PH_BOOST,
        PH_COAST,
        PH_DESCENT,
        PH_LANDED
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PHASE,
        ST_MUL,
        ST_ADD,
        ST_DRAIN,
        ST_FINISH
    } ctl_state_t;

    typedef struct packed {
        logic       load_in;
        logic       phase;
        logic       mul;
        logic       add;
        logic [2:0] idx;
        logic       load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic [SPAN_W-1:0]        span;
        logic [RECIP_W-1:0]       recip;
        logic signed [VAL_W-1:0]  offset;
        logic                     use_extra;
    } draw_param_t;

    function automatic draw_param_t mk_param(input logic [SPAN_W-1:0] span,
                                             input logic [RECIP_W-1:0] recip,
                                             input logic signed [VAL_W-1:0] offset,
                                             input logic use_extra);
        draw_param_t p;
        p.span      = span;
        p.recip     = recip;
        p.offset    = offset;
        p.use_extra = use_extra;
        return p;
    endfunction

    // offset is the low end of the noise range plus the fixed base
    function automatic draw_param_t draw_param(input phase_t ph, input logic [2:0] idx);
        draw_param_t p;
        p = mk_param(10'd31, RECIP_31, -14'sd15, 1'b0);
        case (ph)
            PH_BOOST:
            begin
                case (idx)
                    DRW_AX, DRW_AY: p = mk_param(10'd201, RECIP_201, -14'sd100, 1'b0);
                    DRW_AZ:         p = mk_param(10'd101, RECIP_101, -14'sd50, 1'b1);
                    DRW_GX, DRW_GY: p = mk_param(10'd401, RECIP_401, -14'sd200, 1'b0);
                    default:        p = mk_param(10'd201, RECIP_201, 14'sd400, 1'b0);
                endcase
            end
            PH_COAST:
            begin
                case (idx)
                    DRW_AX, DRW_AY, DRW_AZ: p = mk_param(10'd61, RECIP_61, -14'sd30, 1'b0);
                    DRW_GX:  p = mk_param(10'd101, RECIP_101, 14'sd250, 1'b0);
                    DRW_GY:  p = mk_param(10'd101, RECIP_101, -14'sd250, 1'b0);
                    default: p = mk_param(10'd101, RECIP_101, 14'sd50, 1'b0);
                endcase
            end
            PH_DESCENT:
            begin
                case (idx)
                    DRW_AX, DRW_AY: p = mk_param(10'd301, RECIP_301, -14'sd150, 1'b0);
                    DRW_AZ:  p = mk_param(10'd161, RECIP_161, -14'sd80, 1'b1);
                    DRW_GX:  p = mk_param(10'd601, RECIP_601, 14'sd700, 1'b0);
                    DRW_GY:  p = mk_param(10'd601, RECIP_601, -14'sd1100, 1'b0);
                    default: p = mk_param(10'd401, RECIP_401, 14'sd300, 1'b0);
                endcase
            end
            default:
            begin
                // pad and landed share the resting profile
                case (idx)
                    DRW_AX, DRW_AY: p = mk_param(10'd31, RECIP_31, -14'sd15, 1'b0);
                    DRW_AZ:         p = mk_param(10'd21, RECIP_21, 14'sd990, 1'b0);
                    DRW_GX, DRW_GY: p = mk_param(10'd101, RECIP_101, -14'sd50, 1'b0);
                    default:        p = mk_param(10'd61, RECIP_61, -14'sd30, 1'b0);
                endcase
            end
        endcase
        return p;
    endfunction

endpackage

// ===== sv/synthetic_imu_flight_profile.sv =====
// top level: synthetic imu flight profile generator
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata[31:0] now_ms
//  m_*       out  m_tvalid/m_tready  m_tdata[103:0] stamp_ms, accel x/y/z, gyro x/y/z
//  cfg_*     in   cfg_we             cfg_addr (register index), cfg_wdata
//
//  an item passes from the idle accept state through phase select, the six lcg draws
//  (a 32x32 multiply step and an add step each), the drain of the modulo pipeline and
//  the load of the result register, which waits while the previous result is untaken;
//  the result is valid once the result register is loaded
//  the whole sequence sets the rate; one item is in flight at a time
//  reset puts the boundaries at 5000/15000/30000/45000 ms and the generator at 42
//  a result waiting on m_tready does not block the next accept; only the next
//  result load waits for the result register to free up
module synthetic_imu_flight_profile
    import sifp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // [31:0] now_ms
    output logic             m_tvalid,
    input  logic             m_tready,
    // [31:0] stamp_ms, [40:32] accel_x, [49:41] accel_y, [63:50] accel_z,
    // [75:64] gyro_x, [87:76] gyro_y, [98:88] gyro_z, [103:99] zero
    output logic [OUT_W-1:0] m_tdata,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_addr,
    input  logic [31:0]      cfg_wdata
);

    ctl_cmd_t cmd;

    // sequencing and output valid
    sifp_ctl u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // boundaries, noise generator and result register
    sifp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .out_data  (m_tdata)
    );

endmodule

// ===== sv/sifp_ctl.sv =====
// control state machine: item sequencing, draw counter and output valid
module sifp_ctl
    import sifp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output ctl_cmd_t cmd
);

    ctl_state_t state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_PHASE;
                end
            end
            ST_PHASE:
            begin
                state_next = ST_MUL;
                cnt_next   = '0;
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (cnt_reg == DRW_GZ)
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
                else
                begin
                    state_next = ST_MUL;
                    cnt_next   = cnt_reg + 3'd1;
                end
            end
            ST_DRAIN:
            begin
                // let the modulo pipeline empty before the result load
                if (cnt_reg == 3'd2)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        cmd.idx  = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_PHASE:  cmd.phase    = 1'b1;
            ST_MUL:    cmd.mul      = 1'b1;
            ST_ADD:    cmd.add      = 1'b1;
            ST_FINISH: cmd.load_out = out_free;
            default:   cmd.idx      = cnt_reg;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten before it was taken");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_PHASE))
        else $error("accepted item did not start phase selection");

    a_draw_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |-> (cnt_reg <= DRW_GZ))
        else $error("draw counter out of range");

    a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (cnt_reg <= 3'd2))
        else $error("drain counter out of range");

    a_finish_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_FINISH) |-> ($past(state_reg) == ST_DRAIN))
        else $error("finish reached without draining");

endmodule

// ===== sv/sifp_dp.sv =====
// datapath: config registers, phase select, lcg, modulo pipeline, result register
module sifp_dp
    import sifp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctl_cmd_t         cmd,
    input  logic [IN_W-1:0]  in_data,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_addr,
    input  logic [31:0]      cfg_wdata,
    output logic [OUT_W-1:0] out_data
);

    logic [31:0] pad_end_reg, boost_end_reg, coast_end_reg, descent_end_reg;
    logic [TIME_W-1:0] now_reg;
    phase_t      phase_reg;
    logic [31:0] elapsed_reg;
    logic [11:0] qdiv_reg;
    logic        sat_reg;
    logic signed [VAL_W-1:0] extra_reg;
    logic [31:0] s_reg;
    logic [31:0] prod_reg;

    logic              v1_reg, v2_reg, v3_reg;
    logic [2:0]        i1_reg, i2_reg, i3_reg;
    logic [RAW_W-1:0]  raw1_reg, raw2_reg;
    logic [QUO_W-1:0]  q_reg;
    logic [RAW_W-1:0]  qs_reg;

    logic [8:0]  ax_reg, ay_reg;
    logic [13:0] az_reg;
    logic [11:0] gx_reg, gy_reg;
    logic [10:0] gz_reg;
    logic [OUT_W-1:0] out_reg;

    phase_t      phase_next;
    logic [31:0] el_boost, el_descent;
    logic [29:0] div_prod;
    logic [35:0] recip_prod;
    logic [20:0] span_prod;
    logic [SPAN_W-1:0] rem;
    logic signed [VAL_W-1:0] val;
    draw_param_t p1, p2, p3;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_end_reg     <= PAD_END_RST;
            boost_end_reg   <= BOOST_END_RST;
            coast_end_reg   <= COAST_END_RST;
            descent_end_reg <= DESCENT_END_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_PAD_END:     pad_end_reg     <= cfg_wdata;
                REG_BOOST_END:   boost_end_reg   <= cfg_wdata;
                REG_COAST_END:   coast_end_reg   <= cfg_wdata;
                REG_DESCENT_END: descent_end_reg <= cfg_wdata;
                default:         pad_end_reg     <= pad_end_reg;
            endcase
        end
    end

    // phase select
    always_comb
    begin
        if (now_reg < pad_end_reg)
        begin
            phase_next = PH_PAD;
        end
        else if (now_reg < boost_end_reg)
        begin
            phase_next = PH_BOOST;
        end
        else if (now_reg < coast_end_reg)
        begin
            phase_next = PH_COAST;
        end
        else if (now_reg < descent_end_reg)
        begin
            phase_next = PH_DESCENT;
        end
        else
        begin
            phase_next = PH_LANDED;
        end
    end

    assign el_boost   = now_reg - pad_end_reg;
    assign el_descent = now_reg - coast_end_reg;
    assign div_prod   = 30'(elapsed_reg[13:0]) * 30'(DIV5_RECIP);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            now_reg <= in_data[TIME_W-1:0];
        end
        if (cmd.phase)
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= (phase_next == PH_BOOST) ? el_boost : el_descent;
        end
        // thrust / drag settle through qdiv_reg and sat_reg into extra_reg after phase select
        qdiv_reg <= div_prod[29:DIV5_SH];
        sat_reg  <= elapsed_reg >= SAT_MS;
        case (phase_reg)
            PH_BOOST:
                extra_reg <= sat_reg ? THRUST_MAX
                                     : THRUST_BASE + $signed({2'b00, qdiv_reg});
            PH_DESCENT:
                extra_reg <= sat_reg ? DRAG_MIN
                                     : DRAG_BASE - $signed({3'b000, qdiv_reg[11:1]});
            default:
                extra_reg <= '0;
        endcase
    end

    // lcg: multiply then add
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg <= NOISE_SEED;
        end
        else if (cmd.add)
        begin
            s_reg <= prod_reg + LCG_ADD;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= s_reg * LCG_MUL;
        end
    end

    // modulo pipeline: reciprocal quotient, back-multiply, subtract and offset
    assign p1 = draw_param(phase_reg, i1_reg);
    assign p2 = draw_param(phase_reg, i2_reg);
    assign p3 = draw_param(phase_reg, i3_reg);

    assign recip_prod = 36'(s_reg[30:16]) * 36'(p1.recip);
    assign span_prod  = 21'(q_reg) * 21'(p2.span);
    assign rem        = SPAN_W'(raw2_reg - qs_reg);
    assign val        = p3.offset + $signed({4'b0000, rem})
                      + (p3.use_extra ? extra_reg : 14'sd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.add;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        i1_reg   <= cmd.idx;
        i2_reg   <= i1_reg;
        i3_reg   <= i2_reg;
        raw1_reg <= s_reg[30:16];
        raw2_reg <= raw1_reg;
        q_reg    <= recip_prod[35:RECIP_SH];
        qs_reg   <= span_prod[RAW_W-1:0];
        if (v3_reg)
        begin
            case (i3_reg)
                DRW_AX:  ax_reg <= val[8:0];
                DRW_AY:  ay_reg <= val[8:0];
                DRW_AZ:  az_reg <= val[13:0];
                DRW_GX:  gx_reg <= val[11:0];
                DRW_GY:  gy_reg <= val[11:0];
                DRW_GZ:  gz_reg <= val[10:0];
                default: ax_reg <= ax_reg;
            endcase
        end
        if (cmd.load_out)
        begin
            out_reg <= {5'b00000, gz_reg, gy_reg, gx_reg, az_reg, ay_reg, ax_reg, now_reg};
        end
    end

    assign out_data = out_reg;

endmodule

// ===== verif/tb_top.sv =====
// testbench for the synthetic imu flight profile: predicted readings checked against the stream
module tb_top;
    import sifp_pkg::*;

    // idle this long once drained before touching the registers
    localparam int SETTLE_CYCLES = 24;
    // cycles with no item moving on either side before the run is declared hung
    localparam int STALL_LIMIT   = 3000;
    // length of the long receiver hold-off that fills the block up
    localparam int HOLD_CYCLES   = 400;

    // one reading as it leaves on m_tdata, lowest field last
    typedef struct packed {
        logic [4:0]         zero_fill;
        logic signed [10:0] gyro_z;
        logic signed [11:0] gyro_y;
        logic signed [11:0] gyro_x;
        logic signed [13:0] accel_z;
        logic signed [8:0]  accel_y;
        logic signed [8:0]  accel_x;
        logic [31:0]        stamp_ms;
    } imu_sample_t;

    // predicts each reading from the request time and keeps them until they come out
    class flight_imu_predictor;
        logic [31:0]  bound [4];
        logic [31:0]  lcg;
        imu_sample_t  readings_due [$];
        int           bad_fields;

        function new();
            bound[REG_PAD_END]     = PAD_END_RST;
            bound[REG_BOOST_END]   = BOOST_END_RST;
            bound[REG_COAST_END]   = COAST_END_RST;
            bound[REG_DESCENT_END] = DESCENT_END_RST;
            lcg        = NOISE_SEED;
            bad_fields = 0;
        endfunction

        function void set_bound(logic [1:0] idx, logic [31:0] value);
            bound[idx] = value;
        endfunction

        // one lcg step, then lo + bits 30..16 mod span
        function int noise(int lo, int hi);
            logic [14:0] raw;
            lcg = lcg * LCG_MUL + LCG_ADD;
            raw = lcg[30:16];
            return lo + int'(raw) % (hi - lo + 1);
        endfunction

        function void note_request(logic [31:0] now);
            imu_sample_t  r;
            phase_t       ph;
            logic [31:0]  q;
            int           lift;
            int           v [6];
            if (now < bound[REG_PAD_END])
                ph = PH_PAD;
            else if (now < bound[REG_BOOST_END])
                ph = PH_BOOST;
            else if (now < bound[REG_COAST_END])
                ph = PH_COAST;
            else if (now < bound[REG_DESCENT_END])
                ph = PH_DESCENT;
            else
                ph = PH_LANDED;
            // draws must stay in accel x, y, z, gyro x, y, z order
            case (ph)
                PH_BOOST:
                begin
                    q    = (now - bound[REG_PAD_END]) / 5;
                    lift = (q >= 3000) ? 6000 : 3000 + int'(q);
                    v[0] = noise(-100, 100);
                    v[1] = noise(-100, 100);
                    v[2] = lift + noise(-50, 50);
                    v[3] = noise(-200, 200);
                    v[4] = noise(-200, 200);
                    v[5] = 500 + noise(-100, 100);
                end
                PH_COAST:
                begin
                    v[0] = noise(-30, 30);
                    v[1] = noise(-30, 30);
                    v[2] = noise(-30, 30);
                    v[3] = 300 + noise(-50, 50);
                    v[4] = -200 + noise(-50, 50);
                    v[5] = 100 + noise(-50, 50);
                end
                PH_DESCENT:
                begin
                    q    = (now - bound[REG_COAST_END]) / 10;
                    lift = (q >= 1500) ? -2000 : -500 - int'(q);
                    v[0] = noise(-150, 150);
                    v[1] = noise(-150, 150);
                    v[2] = lift + noise(-80, 80);
                    v[3] = 1000 + noise(-300, 300);
                    v[4] = -800 + noise(-300, 300);
                    v[5] = 500 + noise(-200, 200);
                end
                default:
                begin
                    // pad and landed: resting on the ground
                    v[0] = noise(-15, 15);
                    v[1] = noise(-15, 15);
                    v[2] = 1000 + noise(-10, 10);
                    v[3] = noise(-50, 50);
                    v[4] = noise(-50, 50);
                    v[5] = noise(-30, 30);
                end
            endcase
            r.zero_fill = '0;
            r.stamp_ms  = now;
            r.accel_x   = 9'(v[0]);
            r.accel_y   = 9'(v[1]);
            r.accel_z   = 14'(v[2]);
            r.gyro_x    = 12'(v[3]);
            r.gyro_y    = 12'(v[4]);
            r.gyro_z    = 11'(v[5]);
            readings_due.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] stamp, longint want, longint seen);
            if (want != seen)
            begin
                bad_fields++;
                if (bad_fields <= 10)
                    $display("mismatch %s at stamp %0d: expected %0d, got %0d",
                             name, stamp, want, seen);
            end
        endfunction

        function void check_reading(imu_sample_t got);
            imu_sample_t want;
            if (readings_due.size() == 0)
            begin
                bad_fields++;
                if (bad_fields <= 10)
                    $display("reading with none expected: stamp %0d", got.stamp_ms);
                return;
            end
            want = readings_due.pop_front();
            compare_field("stamp_ms", want.stamp_ms, want.stamp_ms, got.stamp_ms);
            compare_field("accel_x", want.stamp_ms, want.accel_x, got.accel_x);
            compare_field("accel_y", want.stamp_ms, want.accel_y, got.accel_y);
            compare_field("accel_z", want.stamp_ms, want.accel_z, got.accel_z);
            compare_field("gyro_x", want.stamp_ms, want.gyro_x, got.gyro_x);
            compare_field("gyro_y", want.stamp_ms, want.gyro_y, got.gyro_y);
            compare_field("gyro_z", want.stamp_ms, want.gyro_z, got.gyro_z);
        endfunction

        function int pending();
            return readings_due.size();
        endfunction
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata   = '0;   // [31:0] now_ms
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    // [31:0] stamp_ms, [40:32] accel_x, [49:41] accel_y, [63:50] accel_z,
    // [75:64] gyro_x, [87:76] gyro_y, [98:88] gyro_z, [103:99] zero
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_we    = 1'b0;
    logic [1:0]       cfg_addr  = '0;
    logic [31:0]      cfg_wdata = '0;

    flight_imu_predictor imu_pred;
    int                  burst_left   = 0;
    int                  stall_cycles = 0;
    bit                  hold_request = 1'b0;

    // register codes in write order
    logic [1:0] reg_codes [4] = '{REG_PAD_END, REG_BOOST_END, REG_COAST_END, REG_DESCENT_END};

    // default boundaries: both sides of every edge, the time extremes, all bits of now_ms
    logic [31:0] rest_times [15] = '{
        32'd0, 32'd4999, 32'd5000, 32'd5001, 32'd5004, 32'd5005, 32'd14999, 32'd15000,
        32'd29999, 32'd30000, 32'd30010, 32'd44999, 32'd45000, 32'h7FFF_FFFF, 32'hFFFF_FFFF
    };

    // boundaries 0/20000/20000/40000: empty coast, thrust and drag just below and at saturation
    logic [31:0] sat_times [9] = '{
        32'd0, 32'd14999, 32'd15000, 32'd19999, 32'd20000,
        32'd34999, 32'd35000, 32'd39999, 32'd40000
    };

    synthetic_imu_flight_profile uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // every reading leaving the block is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            imu_pred.check_reading(imu_sample_t'(m_tdata));
    end

    // hang detection: count cycles in which no item moves on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: a random stall pattern, redrawn periodically, plus a long hold-off on request
    initial
    begin
        int mode;
        int cyc;
        int hold_left;
        mode      = 0;
        cyc       = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 64 == 0)
                mode = $urandom_range(0, 3);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= cyc[2];
                endcase
            end
        end
    end

    // offer one request and hold it until taken; bursts end in a random gap
    // called and returns at a falling edge, so valid is never lowered and raised in one step
    task automatic send_request(input logic [31:0] now);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= now;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        imu_pred.note_request(now);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(1, 30);
            // mostly short bursts, now and then a long one with no idling
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;   // junk on the bus while idle
            repeat (gap) @(negedge clk);
        end
    endtask

    // stop offering until every predicted reading has come out, then let the block settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (imu_pred.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // rewrite all four phase boundaries, one register per cycle, with the block idle
    task automatic write_bounds(input logic [31:0] pad_end, input logic [31:0] boost_end,
                                input logic [31:0] coast_end, input logic [31:0] descent_end);
        logic [31:0] vals [4];
        vals = '{pad_end, boost_end, coast_end, descent_end};
        wait_drained();
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= reg_codes[i];
            cfg_wdata <= vals[i];
            imu_pred.set_bound(reg_codes[i], vals[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // request times aimed at the current boundaries, with some fully random ones
    function automatic logic [31:0] pick_time();
        longint      top;
        int unsigned lim;
        int          k;
        top = 0;
        for (int j = 0; j < 4; j++)
            if (imu_pred.bound[j] > top)
                top = imu_pred.bound[j];
        top = top + 5000;
        lim = (top > 64'd4294967295) ? 32'hFFFF_FFFF : top[31:0];
        k   = $urandom_range(0, 99);
        if (k < 10)
            return $urandom;
        else if (k < 40)
            // right around an edge
            return imu_pred.bound[$urandom_range(0, 3)] + 32'($urandom_range(0, 8)) - 32'd4;
        else if (k < 55)
            // deep into the thrust ramp and past its saturation
            return imu_pred.bound[REG_PAD_END] + 32'($urandom_range(0, 20000));
        else if (k < 70)
            // along the drag ramp and past its saturation
            return imu_pred.bound[REG_COAST_END] + 32'($urandom_range(0, 20000));
        else
            return $urandom_range(0, lim);
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            // once in a while drain completely before going on
            if ($urandom_range(0, 149) == 0)
                wait_drained();
            send_request(pick_time());
        end
    endtask

    initial
    begin
        imu_pred = new();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset boundaries: directed edges first, then random
        foreach (rest_times[i])
            send_request(rest_times[i]);
        wait_drained();
        run_random(250);

        // ramps that reach saturation, with the receiver holding off so the input backs up
        write_bounds(32'd0, 32'd20000, 32'd20000, 32'd40000);
        hold_request = 1'b1;
        foreach (sat_times[i])
            send_request(sat_times[i]);
        run_random(250);

        // tight boundaries, every phase within a few hundred ms
        write_bounds(32'd100, 32'd200, 32'd300, 32'd400);
        run_random(250);

        // boundaries out of order: boost is never reached, coast spans the gap
        write_bounds(32'd30000, 32'd10000, 32'd50000, 32'd20000);
        hold_request = 1'b1;
        run_random(250);

        // huge boost and descent windows, elapsed times far past saturation
        write_bounds(32'd0, 32'h8000_0000, 32'h9000_0000, 32'hFFFF_FFFF);
        run_random(250);

        // all boundaries at the top: pad everywhere but the very last ms
        write_bounds(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF);
        run_random(100);

        // all boundaries at zero: always landed
        write_bounds(32'd0, 32'd0, 32'd0, 32'd0);
        run_random(100);

        // random ordered boundaries
        begin
            logic [31:0] b0;
            logic [31:0] b1;
            logic [31:0] b2;
            logic [31:0] b3;
            b0 = $urandom_range(0, 100000);
            b1 = b0 + $urandom_range(0, 100000);
            b2 = b1 + $urandom_range(0, 100000);
            b3 = b2 + $urandom_range(0, 100000);
            write_bounds(b0, b1, b2, b3);
        end
        run_random(200);

        // back to the reset boundaries
        write_bounds(PAD_END_RST, BOOST_END_RST, COAST_END_RST, DESCENT_END_RST);
        run_random(100);

        wait_drained();
        if (imu_pred.bad_fields == 0 && imu_pred.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
